FILE: src/lpc_pkg.sv
`timescale 1ns / 1ps
package lpc_pkg;

   localparam int DEF_ENTRIES   = 256;
   localparam int DEF_DEVICES   = 16;
   localparam int DEF_MAX_COUNT = 64;

   localparam logic [2:0] CMD_READ      = 3'd0;
   localparam logic [2:0] CMD_WRITE     = 3'd1;
   localparam logic [2:0] CMD_FLUSH_DEV = 3'd2;
   localparam logic [2:0] CMD_FLUSH_ALL = 3'd3;
   localparam logic [2:0] CMD_FILL_FAIL = 3'd4;

   typedef enum logic [2:0] {
      ST_CHUNK      = 3'd0,
      ST_REJECT     = 3'd1,
      ST_FLUSH_WB   = 3'd2,
      ST_FLUSH_DONE = 3'd3,
      ST_INVAL      = 3'd4
   } status_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [3:0]  device;
      logic [47:0] lba;
      logic [6:0]  count;
      logic [1:0]  page_shift;
      logic        dev_readable;
      logic        dev_writable;
      logic [7:0]  failed_entry;
   } req_type;

   typedef struct packed {
      status_type  status;
      logic        hit;
      logic [7:0]  entry;
      logic [47:0] page_addr;
      logic [2:0]  page_offset;
      logic [3:0]  chunk_len;
      logic        fill_needed;
      logic        wb_needed;
      logic [3:0]  wb_device;
      logic [47:0] wb_addr;
      logic [3:0]  wb_sectors;
      logic        last;
   } rsp_type;

   // one tag entry as held in the tag memory
   typedef struct packed {
      logic [3:0]  device;
      logic [47:0] page;
      logic [3:0]  sectors;
      logic        writable;
      logic [63:0] stamp;
   } rec_type;

   typedef struct packed {
      logic        flush_mode;
      logic        flush_all;
      logic [3:0]  device;
      logic [47:0] page;
   } scan_ctl_type;

   typedef struct packed {
      logic hit_found;
      logic free_found;
      logic victim_wb;
      logic fl_take;
      logic fl_stop;
   } scan_flags_type;

endpackage

FILE: src/lpc_scan.sv
`timescale 1ns / 1ps
module lpc_scan #(
   parameter int IW = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   clr,
   input  logic                   ev,
   input  logic [IW-1:0]          idx,
   input  lpc_pkg::rec_type       rec,
   input  logic                   valid,
   input  logic                   dirty,
   input  lpc_pkg::scan_ctl_type  ctl,
   output lpc_pkg::scan_flags_type flags,
   output logic [IW-1:0]          hit_idx,
   output logic [3:0]             hit_secs,
   output logic [IW-1:0]          free_idx,
   output logic [IW-1:0]          old_idx,
   output lpc_pkg::rec_type       victim
);
   import lpc_pkg::*;

   logic          hit_found_ff, free_found_ff, old_have_ff, victim_wb_ff;
   logic [IW-1:0] hit_idx_ff, free_idx_ff, old_idx_ff;
   logic [3:0]    hit_secs_ff;
   rec_type       victim_ff;
   logic          dev_eq, match_now, fl_now, older;

   always_comb begin
      dev_eq    = (rec.device == ctl.device);
      match_now = valid && dev_eq && (rec.page == ctl.page);
      fl_now    = valid && dirty && (ctl.flush_all || dev_eq);
      // the shared stamp comparator
      older     = !old_have_ff || (rec.stamp < victim_ff.stamp);
   end

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         old_have_ff   <= 1'b0;
         victim_wb_ff  <= 1'b0;
      end else if (ev && !ctl.flush_mode) begin
         if (match_now && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= idx;
            // keep the page size the entry was filled with
            hit_secs_ff  <= rec.sectors;
         end
         if (!valid && !free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= idx;
         end
         if (valid && !free_found_ff && older) begin
            old_have_ff  <= 1'b1;
            old_idx_ff   <= idx;
            victim_ff    <= rec;
            victim_wb_ff <= dirty && rec.writable;
         end
      end
   end

   always_comb begin
      flags.hit_found  = hit_found_ff;
      flags.free_found = free_found_ff;
      flags.victim_wb  = victim_wb_ff;
      flags.fl_take    = ev && ctl.flush_mode && fl_now;
      flags.fl_stop    = ev && ctl.flush_mode && fl_now && rec.writable;
      hit_idx          = hit_idx_ff;
      hit_secs         = hit_secs_ff;
      free_idx         = free_idx_ff;
      old_idx          = old_idx_ff;
      victim           = victim_ff;
   end

endmodule

FILE: src/lru_page_cache_tag_engine_unit.sv
`timescale 1ns / 1ps
// Timing: a chunk result is offered after its request or the previous chunk transfer once
// the tag reads through the single stamp/tag comparator and then the commit state are done.
// A flush result is offered when the scan finds a writable dirty entry or ends; reject,
// empty and fill-failed results are registered straight from the request transfer.
// Throughput: one item at a time; a new request is taken only after the last result transfer.
// Reset: synchronous, active high; clears valid and dirty bits, use clock, FSM.
module lru_page_cache_tag_engine_unit #(
   parameter int ENTRIES   = lpc_pkg::DEF_ENTRIES,
   parameter int DEVICES   = lpc_pkg::DEF_DEVICES,
   parameter int MAX_COUNT = lpc_pkg::DEF_MAX_COUNT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  lpc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output lpc_pkg::rsp_type rsp_data
);
   import lpc_pkg::*;

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = IW + 1;

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_COMMIT, S_RESP} state_type;

   state_type     state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;
   logic [2:0]    cmd_ff, cmd_in;
   logic [3:0]    dev_ff, dev_in;
   logic [1:0]    ps_ff, ps_in;
   logic          wr_ff, wr_in;
   logic [47:0]   cur_ff, cur_in;
   logic [6:0]    rem_ff, rem_in;
   logic          more_ff, more_in;
   logic [63:0]   use_clock_ff, use_clock_in;
   logic [CW-1:0] scan_ff, scan_in;
   logic          rd_vld_ff, rd_vld_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [ENTRIES-1:0] valid_ff, valid_in, dirty_ff, dirty_in;

   // tag memory: one read port (registered), one write port
   rec_type       mem [ENTRIES];
   rec_type       rd_rec_ff;
   logic          mem_we;
   logic [IW-1:0] mem_waddr;
   rec_type       mem_wdata;

   // scan unit
   logic           scan_clr, scan_ev;
   scan_ctl_type   sctl;
   scan_flags_type sflags;
   logic [IW-1:0]  hit_idx, free_idx, old_idx, sel_idx, fe_idx;
   logic [3:0]     hit_secs;
   rec_type        victim;

   // chunk arithmetic on the current sector address
   logic [3:0]  spp, len_full, len;
   logic [2:0]  off, pmask;
   logic [47:0] page_now;
   logic [6:0]  rem_next;
   logic        flush_mode, req_bad, is_hit, is_free;

   lpc_scan #(.IW(IW)) u_scan (
      .clock    (clock),
      .reset    (reset),
      .clr      (scan_clr),
      .ev       (scan_ev),
      .idx      (rd_idx_ff),
      .rec      (rd_rec_ff),
      .valid    (valid_ff[rd_idx_ff]),
      .dirty    (dirty_ff[rd_idx_ff]),
      .ctl      (sctl),
      .flags    (sflags),
      .hit_idx  (hit_idx),
      .hit_secs (hit_secs),
      .free_idx (free_idx),
      .old_idx  (old_idx),
      .victim   (victim)
   );

   always_comb begin
      spp      = 4'd1 << ps_ff;
      pmask    = 3'(spp - 4'd1);
      off      = cur_ff[2:0] & pmask;
      page_now = cur_ff & ~{45'd0, pmask};
      len_full = spp - {1'b0, off};
      len      = (7'(len_full) > rem_ff) ? rem_ff[3:0] : len_full;
      rem_next = rem_ff - 7'(len);
      flush_mode = (cmd_ff == CMD_FLUSH_DEV) || (cmd_ff == CMD_FLUSH_ALL);
      sctl.flush_mode = flush_mode;
      sctl.flush_all  = (cmd_ff == CMD_FLUSH_ALL);
      sctl.device     = dev_ff;
      sctl.page       = page_now;
      scan_ev  = rd_vld_ff && (state_ff == S_SCAN);
      is_hit   = sflags.hit_found;
      is_free  = sflags.free_found;
      sel_idx  = is_hit ? hit_idx : (is_free ? free_idx : old_idx);
      fe_idx   = IW'(req_data.failed_entry);
      req_bad  = (req_data.cmd > CMD_FILL_FAIL)
              || (32'(req_data.device) >= DEVICES)
              || (32'(req_data.count) > MAX_COUNT)
              || ((req_data.cmd == CMD_READ) && !req_data.dev_readable)
              || ((req_data.cmd == CMD_WRITE) && !req_data.dev_writable);
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      cmd_in       = cmd_ff;
      dev_in       = dev_ff;
      ps_in        = ps_ff;
      wr_in        = wr_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      more_in      = more_ff;
      use_clock_in = use_clock_ff;
      scan_in      = scan_ff;
      rd_vld_in    = 1'b0;
      rd_idx_in    = scan_ff[IW-1:0];
      valid_in     = valid_ff;
      dirty_in     = dirty_ff;
      scan_clr     = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = sel_idx;
      mem_wdata.device   = dev_ff;
      mem_wdata.page     = page_now;
      // a hit keeps the page size of the original fill
      mem_wdata.sectors  = is_hit ? hit_secs : spp;
      mem_wdata.writable = wr_ff;
      mem_wdata.stamp    = use_clock_ff + 64'd1;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               // latch the request and decide its path
               cmd_in  = req_data.cmd;
               dev_in  = req_data.device;
               ps_in   = req_data.page_shift;
               wr_in   = req_data.dev_writable;
               cur_in  = req_data.lba;
               rem_in  = req_data.count;
               more_in = 1'b0;
               rsp_in      = '0;
               rsp_in.last = 1'b1;
               scan_in     = '0;
               if (req_data.cmd == CMD_FILL_FAIL) begin
                  rsp_in.status = ST_INVAL;
                  rsp_in.entry  = req_data.failed_entry;
                  if (32'(req_data.failed_entry) < ENTRIES) begin
                     valid_in[fe_idx] = 1'b0;
                     dirty_in[fe_idx] = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = S_RESP;
               end else if (req_data.cmd == CMD_FLUSH_DEV
                            && 32'(req_data.device) >= DEVICES) begin
                  rsp_in.status = ST_REJECT;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_RESP;
               end else if (req_data.cmd == CMD_FLUSH_DEV
                            || req_data.cmd == CMD_FLUSH_ALL) begin
                  scan_clr = 1'b1;
                  state_in = S_SCAN;
               end else if (req_bad) begin
                  rsp_in.status = ST_REJECT;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_RESP;
               end else if (req_data.count == 7'd0) begin
                  rsp_in.status = ST_CHUNK;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  scan_clr = 1'b1;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // issue one tag read per cycle, evaluate the previous one
            if (scan_ff != CW'(ENTRIES)) begin
               rd_vld_in = 1'b1;
               scan_in   = scan_ff + CW'(1);
            end
            if (sflags.fl_take) begin
               dirty_in[rd_idx_ff] = 1'b0;
            end
            if (sflags.fl_stop) begin
               rsp_in            = '0;
               rsp_in.status     = ST_FLUSH_WB;
               rsp_in.entry      = 8'(rd_idx_ff);
               rsp_in.wb_needed  = 1'b1;
               rsp_in.wb_device  = rd_rec_ff.device;
               rsp_in.wb_addr    = rd_rec_ff.page;
               rsp_in.wb_sectors = rd_rec_ff.sectors;
               rsp_in.last       = 1'b1;
               rsp_valid_in      = 1'b1;
               rd_vld_in         = 1'b0;
               state_in          = S_RESP;
            end else if (scan_ff == CW'(ENTRIES) && !rd_vld_ff) begin
               if (flush_mode) begin
                  rsp_in        = '0;
                  rsp_in.status = ST_FLUSH_DONE;
                  rsp_in.last   = 1'b1;
                  rsp_valid_in  = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_COMMIT;
               end
            end
         end
         S_COMMIT: begin
            // write the chosen entry and form the chunk result
            mem_we            = 1'b1;
            valid_in[sel_idx] = 1'b1;
            if (cmd_ff == CMD_WRITE) begin
               dirty_in[sel_idx] = 1'b1;
            end else if (!is_hit) begin
               dirty_in[sel_idx] = 1'b0;
            end
            use_clock_in       = use_clock_ff + 64'd1;
            rsp_in             = '0;
            rsp_in.status      = ST_CHUNK;
            rsp_in.hit         = is_hit;
            rsp_in.entry       = 8'(sel_idx);
            rsp_in.page_addr   = page_now;
            rsp_in.page_offset = off;
            rsp_in.chunk_len   = len;
            rsp_in.fill_needed = !is_hit && ((cmd_ff == CMD_READ) || (len < spp));
            if (!is_hit && !is_free && sflags.victim_wb) begin
               rsp_in.wb_needed  = 1'b1;
               rsp_in.wb_device  = victim.device;
               rsp_in.wb_addr    = victim.page;
               rsp_in.wb_sectors = victim.sectors;
            end
            rsp_in.last  = (rem_next == 7'd0);
            more_in      = (rem_next != 7'd0);
            rem_in       = rem_next;
            cur_in       = cur_ff + 48'(len);
            rsp_valid_in = 1'b1;
            state_in     = S_RESP;
         end
         S_RESP: begin
            // hold the result until the transfer, then next chunk or idle
            if (rsp_ready) begin
               rsp_valid_in = 1'b0;
               if (more_ff) begin
                  scan_clr = 1'b1;
                  scan_in  = '0;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         more_ff      <= 1'b0;
         use_clock_ff <= '0;
         scan_ff      <= '0;
         rd_vld_ff    <= 1'b0;
         valid_ff     <= '0;
         dirty_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         more_ff      <= more_in;
         use_clock_ff <= use_clock_in;
         scan_ff      <= scan_in;
         rd_vld_ff    <= rd_vld_in;
         valid_ff     <= valid_in;
         dirty_ff     <= dirty_in;
      end
      rsp_ff    <= rsp_in;
      cmd_ff    <= cmd_in;
      dev_ff    <= dev_in;
      ps_ff     <= ps_in;
      wr_ff     <= wr_in;
      cur_ff    <= cur_in;
      rem_ff    <= rem_in;
      rd_idx_ff <= rd_idx_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_rec_ff <= mem[rd_idx_in];
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

FILE: src/lpc_checker.sv
`timescale 1ns / 1ps
module lpc_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input lpc_pkg::rsp_type rsp_data
);
   import lpc_pkg::*;

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result dropped or changed while stalled");

   // one item at a time: never take a request while a result waits
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request taken with a result pending");

   // drop ready once a request transfer has happened
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready held after a request transfer");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_CHUNK |-> rsp_data.last)
      else $error("non-chunk result without last");

   a_wb_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.wb_needed |-> rsp_data.wb_sectors == 4'd0)
      else $error("writeback sectors without writeback");

endmodule

bind lru_page_cache_tag_engine_unit lpc_checker u_lpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

FILE: sim/tb_lru_page_cache_tag_engine_unit.sv
`timescale 1ns / 1ps
module tb_lru_page_cache_tag_engine_unit;
   import lpc_pkg::*;

   localparam int NUM_ENTRIES = DEF_ENTRIES;
   localparam int NUM_RANDOM  = 440;
   localparam int CYCLE_LIMIT = 40000000;
   localparam int DRAIN_WAIT  = 300;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   lru_page_cache_tag_engine_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // shadow copy of the tag store, kept in step with every accepted transfer
   bit          tag_valid [NUM_ENTRIES];
   logic [3:0]  tag_dev   [NUM_ENTRIES];
   logic [47:0] tag_page  [NUM_ENTRIES];
   logic [3:0]  tag_secs  [NUM_ENTRIES];
   bit          tag_wr    [NUM_ENTRIES];
   bit          tag_dirty [NUM_ENTRIES];
   logic [63:0] tag_stamp [NUM_ENTRIES];
   logic [63:0] use_ctr;

   rsp_type pending_rsps [$];
   int      mismatches;
   int      cycles;
   int      send_idle_pct;
   int      rsp_stall_pct;
   bit      hold_request;
   int      hold_left;

   typedef struct {
      req_type req;
      bit      typed;
      rsp_type rsp;
   } stim_row_type;

   stim_row_type directed [$];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // watchdog: give up on a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   function automatic req_type mk(logic [2:0] c, logic [3:0] dev, logic [47:0] lba,
                                  logic [6:0] cnt, logic [1:0] ps, logic rd, logic wr,
                                  logic [7:0] fe);
      req_type r;
      r.cmd = c; r.device = dev; r.lba = lba; r.count = cnt; r.page_shift = ps;
      r.dev_readable = rd; r.dev_writable = wr; r.failed_entry = fe;
      return r;
   endfunction

   function automatic rsp_type single_rsp(status_type s, logic [7:0] e);
      rsp_type o;
      o = '0;
      o.status = s;
      o.entry  = e;
      o.last   = 1'b1;
      return o;
   endfunction

   // work out the results of one transfer and advance the shadow tag store
   task automatic predict_tags(input req_type r);
      rsp_type     o;
      int          idx, oldest, rem, len, spp, i;
      bit          hit, found;
      logic [63:0] otime;
      logic [47:0] cur, page;
      o = '0;
      o.last = 1'b1;
      if (r.cmd == CMD_FILL_FAIL) begin
         tag_valid[r.failed_entry] = 0;
         tag_dirty[r.failed_entry] = 0;
         pending_rsps.push_back(single_rsp(ST_INVAL, r.failed_entry));
      end else if (r.cmd == CMD_FLUSH_DEV || r.cmd == CMD_FLUSH_ALL) begin
         found = 0;
         for (i = 0; i < NUM_ENTRIES && !found; i++) begin
            if (tag_valid[i] && tag_dirty[i] &&
                (r.cmd == CMD_FLUSH_ALL || tag_dev[i] == r.device)) begin
               tag_dirty[i] = 0;
               // read-only entries are cleaned without a writeback
               if (tag_wr[i]) begin
                  found = 1;
                  o = single_rsp(ST_FLUSH_WB, 8'(i));
                  o.wb_needed = 1'b1;
                  o.wb_device = tag_dev[i];
                  o.wb_addr = tag_page[i];
                  o.wb_sectors = tag_secs[i];
               end
            end
         end
         pending_rsps.push_back(found ? o : single_rsp(ST_FLUSH_DONE, 8'd0));
      end else if (r.cmd > CMD_FILL_FAIL || r.count > DEF_MAX_COUNT ||
                   (r.cmd == CMD_READ && !r.dev_readable) ||
                   (r.cmd == CMD_WRITE && !r.dev_writable)) begin
         pending_rsps.push_back(single_rsp(ST_REJECT, 8'd0));
      end else if (r.count == 0) begin
         pending_rsps.push_back(single_rsp(ST_CHUNK, 8'd0));
      end else begin
         spp = 1 << r.page_shift;
         cur = r.lba;
         rem = r.count;
         while (rem > 0) begin
            page = cur & ~48'(spp - 1);
            len = spp - int'(cur & 48'(spp - 1));
            if (len > rem) len = rem;
            o = '0;
            o.status = ST_CHUNK;
            o.page_offset = 3'(cur & 48'(spp - 1));
            idx = -1;
            hit = 0;
            for (i = 0; i < NUM_ENTRIES && !hit; i++) begin
               if (tag_valid[i] && tag_dev[i] == r.device && tag_page[i] == page) begin
                  idx = i;
                  hit = 1;
               end
            end
            if (!hit) begin
               // lowest free entry first, else the oldest stamp
               oldest = 0;
               otime = '1;
               for (i = 0; i < NUM_ENTRIES && idx < 0; i++) begin
                  if (!tag_valid[i]) idx = i;
                  else if (tag_stamp[i] < otime) begin
                     otime = tag_stamp[i];
                     oldest = i;
                  end
               end
               if (idx < 0) begin
                  idx = oldest;
                  if (tag_dirty[idx] && tag_wr[idx]) begin
                     o.wb_needed = 1'b1;
                     o.wb_device = tag_dev[idx];
                     o.wb_addr = tag_page[idx];
                     o.wb_sectors = tag_secs[idx];
                  end
               end
               tag_valid[idx] = 1;
               tag_dev[idx] = r.device;
               tag_page[idx] = page;
               tag_secs[idx] = 4'(spp);
               tag_dirty[idx] = 0;
               o.fill_needed = (r.cmd == CMD_READ) || (len < spp);
            end
            tag_wr[idx] = r.dev_writable;
            use_ctr = use_ctr + 1;
            tag_stamp[idx] = use_ctr;
            if (r.cmd == CMD_WRITE) tag_dirty[idx] = 1;
            rem -= len;
            cur = cur + 48'(len);
            o.hit = hit;
            o.entry = 8'(idx);
            o.page_addr = page;
            o.chunk_len = 4'(len);
            o.last = (rem == 0);
            pending_rsps.push_back(o);
         end
      end
   endtask

   function automatic string diff_fields(rsp_type e, rsp_type g);
      string s;
      s = "";
      if (e.status !== g.status) s = {s, " status"};
      if (e.hit !== g.hit) s = {s, " hit"};
      if (e.entry !== g.entry) s = {s, " entry"};
      if (e.page_addr !== g.page_addr) s = {s, " page_addr"};
      if (e.page_offset !== g.page_offset) s = {s, " page_offset"};
      if (e.chunk_len !== g.chunk_len) s = {s, " chunk_len"};
      if (e.fill_needed !== g.fill_needed) s = {s, " fill_needed"};
      if (e.wb_needed !== g.wb_needed) s = {s, " wb_needed"};
      if (e.wb_device !== g.wb_device) s = {s, " wb_device"};
      if (e.wb_addr !== g.wb_addr) s = {s, " wb_addr"};
      if (e.wb_sectors !== g.wb_sectors) s = {s, " wb_sectors"};
      if (e.last !== g.last) s = {s, " last"};
      return s;
   endfunction

   // check every result transfer against the oldest pending one
   always @(posedge clock) begin
      rsp_type exp_rsp;
      string   bad;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", rsp_data);
         end else begin
            exp_rsp = pending_rsps.pop_front();
            bad = diff_fields(exp_rsp, rsp_data);
            if (bad != "") begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch in%s: exp %h got %h", bad, exp_rsp, rsp_data);
            end
         end
      end
   end

   // result side: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_request) begin
         hold_request = 0;
         hold_left = 3000;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // offer one transfer, hold it until taken, then predict its results
   task automatic send_req(input req_type r, input bit typed, input rsp_type typed_rsp);
      int n;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (typed) begin
         // advance the shadow store, but check against the typed-in value
         n = pending_rsps.size();
         predict_tags(r);
         while (pending_rsps.size() > n) void'(pending_rsps.pop_back());
         pending_rsps.push_back(typed_rsp);
      end else begin
         predict_tags(r);
      end
   endtask

   function automatic req_type random_req();
      req_type r;
      int      p;
      r.cmd = 3'($urandom_range(0, 1));
      r.device = 4'($urandom_range(0, 3));
      r.page_shift = 2'($urandom_range(0, 3));
      r.dev_readable = ($urandom_range(0, 9) != 0);
      r.dev_writable = ($urandom_range(0, 9) != 0);
      r.failed_entry = 8'($urandom);
      r.count = 7'($urandom_range(1, 12));
      r.lba = ($urandom_range(0, 1)) ? 48'($urandom_range(0, 63)) :
                                       48'($urandom_range(0, 2047));
      p = $urandom_range(0, 99);
      if (p < 3) r.count = 7'(DEF_MAX_COUNT);
      else if (p < 8) r.lba = 48'hFFFF_FFFF_FFF0 + 48'($urandom_range(0, 15));
      else if (p < 18) r.lba = 48'({$urandom, $urandom});
      else if (p < 30) r.cmd = ($urandom_range(0, 1)) ? CMD_FLUSH_DEV : CMD_FLUSH_ALL;
      else if (p < 38) r.cmd = CMD_FILL_FAIL;
      else if (p < 44) r.count = 7'($urandom_range(DEF_MAX_COUNT + 1, 127));
      else if (p < 54) begin
         // raw noise; keep accepted requests short
         r = req_type'({$urandom, $urandom, $urandom});
         if (r.count <= DEF_MAX_COUNT) r.count = r.count % 9;
      end
      return r;
   endfunction

   initial begin
      int k;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      cycles = 0;
      mismatches = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_request = 0;
      hold_left = 0;
      use_ctr = '0;
      for (k = 0; k < NUM_ENTRIES; k++) begin
         tag_valid[k] = 0; tag_dirty[k] = 0; tag_stamp[k] = '0;
         tag_dev[k] = '0; tag_page[k] = '0; tag_secs[k] = '0; tag_wr[k] = 0;
      end

      directed.push_back('{mk(CMD_READ, 0, 0, 1, 0, 0, 1, 0), 1, single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(CMD_WRITE, 0, 0, 1, 0, 1, 0, 0), 1, single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(CMD_READ, 1, 0, 65, 0, 1, 1, 0), 1, single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(CMD_WRITE, 1, 0, 127, 3, 1, 1, 0), 1,
                           single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(3'd5, 0, 0, 1, 0, 1, 1, 0), 1, single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(3'd6, 0, 0, 1, 0, 1, 1, 0), 1, single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(3'd7, 15, '1, 127, 3, 1, 1, 255), 1,
                           single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(CMD_READ, 2, 100, 0, 2, 1, 1, 0), 1,
                           single_rsp(ST_CHUNK, 0)});
      directed.push_back('{mk(CMD_FLUSH_ALL, 0, 0, 0, 0, 1, 1, 0), 1,
                           single_rsp(ST_FLUSH_DONE, 0)});
      directed.push_back('{mk(CMD_FILL_FAIL, 0, 0, 0, 0, 1, 1, 255), 1,
                           single_rsp(ST_INVAL, 255)});
      directed.push_back('{mk(CMD_READ, 0, 0, 1, 0, 1, 1, 0), 0, '0});
      // wraps past the top of the sector space
      directed.push_back('{mk(CMD_WRITE, 15, 48'hFFFF_FFFF_FFFD, 8, 3, 1, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_WRITE, 15, 0, 64, 2, 1, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_READ, 0, 0, 3, 1, 1, 0, 0), 0, '0});
      directed.push_back('{mk(CMD_WRITE, 3, 5, 2, 1, 0, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_WRITE, 3, 9, 1, 2, 0, 0, 0), 1, single_rsp(ST_REJECT, 0)});
      directed.push_back('{mk(CMD_FLUSH_DEV, 15, 0, 0, 0, 1, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_FLUSH_DEV, 15, 0, 0, 0, 1, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_FLUSH_ALL, 0, 0, 0, 0, 1, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_FILL_FAIL, 0, 0, 0, 0, 1, 1, 0), 1,
                           single_rsp(ST_INVAL, 0)});
      directed.push_back('{mk(CMD_WRITE, 7, 48'h8000_0000_0000, 1, 0, 1, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_READ, 7, 48'h8000_0000_0000, 1, 0, 1, 1, 0), 0, '0});
      directed.push_back('{mk(CMD_FILL_FAIL, 0, 0, 0, 0, 1, 1, 1), 1,
                           single_rsp(ST_INVAL, 1)});

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_req(directed[i].req, directed[i].typed, directed[i].rsp);

      for (k = 0; k < NUM_RANDOM; k++) begin
         // advance through the idling phases
         case (k / 110)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 52; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 52; end
            default: begin send_idle_pct = 12; rsp_stall_pct = 12; end
         endcase
         if (k == 60) hold_request = 1;
         if (k == 300) begin
            // drop valid and let the result side empty out completely
            req_valid <= 1'b0;
            @(posedge clock);
            while (pending_rsps.size() != 0) @(posedge clock);
         end
         send_req(random_req(), 0, '0);
      end
      req_valid <= 1'b0;

      while (pending_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: lru_page_cache_tag_engine_unit.f
src/lpc_pkg.sv
src/lpc_scan.sv
src/lru_page_cache_tag_engine_unit.sv
src/lpc_checker.sv
sim/tb_lru_page_cache_tag_engine_unit.sv
